/* hdl/tdes_pkg.sv */
// tdes_pkg: constants, permutation tables and des round functions
// used by the round cell, the key setup and the top level; no dependencies
package tdes_pkg;

	localparam int RoundCount = 16;
	localparam int CellCount  = 48;
	localparam int IdxW = 3;

	localparam logic [IdxW-1:0] RegKeyFirst  = 3'd0;
	localparam logic [IdxW-1:0] RegKeySecond = 3'd1;
	localparam logic [IdxW-1:0] RegKeyThird  = 3'd2;
	localparam logic [IdxW-1:0] RegDirection = 3'd3;
	localparam logic [IdxW-1:0] RegTriple    = 3'd4;

	typedef logic [47:0] subkey_t;
	typedef subkey_t subkeys_t [RoundCount];

	typedef struct packed {
		logic        valid;
		logic        last;
		logic [31:0] l;
		logic [31:0] r;
	} cell_data_t;

	localparam logic [7:0] TabIp [64] = '{
		58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
		62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
		57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
		61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7};
	localparam logic [7:0] TabFp [64] = '{
		40, 8, 48, 16, 56, 24, 64, 32, 39, 7, 47, 15, 55, 23, 63, 31,
		38, 6, 46, 14, 54, 22, 62, 30, 37, 5, 45, 13, 53, 21, 61, 29,
		36, 4, 44, 12, 52, 20, 60, 28, 35, 3, 43, 11, 51, 19, 59, 27,
		34, 2, 42, 10, 50, 18, 58, 26, 33, 1, 41, 9, 49, 17, 57, 25};
	localparam logic [7:0] TabE [48] = '{
		32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9, 8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
		16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25, 24, 25, 26, 27, 28, 29, 28, 29,
		30, 31, 32, 1};
	localparam logic [7:0] TabP [32] = '{
		16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
		2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25};
	localparam logic [7:0] TabPc1 [56] = '{
		57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
		10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
		63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
		14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4};
	localparam logic [7:0] TabPc2 [48] = '{
		14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
		23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
		41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
		44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};
	localparam logic [1:0] TabShift [16] = '{
		1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};
	localparam logic [3:0] TabSbox [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	function automatic logic [63:0] ip_perm(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabIp[i])];
		return r;
	endfunction

	function automatic logic [63:0] fp_perm(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabFp[i])];
		return r;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
		logic [47:0] x;
		logic [31:0] s;
		logic [5:0]  six;
		logic [31:0] p;
		for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TabE[i])];
		x = x ^ k;
		for (int b = 0; b < 8; b++) begin
			six = x[47-6*b -: 6];
			s[31-4*b -: 4] = TabSbox[b][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
		return p;
	endfunction

	function automatic logic [27:0] rotl28(input logic [27:0] x, input logic [1:0] s);
		return (s == 2'd1) ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
	endfunction

endpackage

/* hdl/triple_des_block_cipher_unit.sv */
// triple_des_block_cipher_unit: top level of the triple des ede / ecb unit
// depends on tdes_pkg, tdes_key_sched and tdes_round_cell
//
// a new block may be started in every clock cycle while busy is low: the
// unit is a chain of 48 round cells (three des passes of 16 rounds), one
// round per cell and cycle. busy is low except in the cycle after each
// register write, while the registered round keys catch up with the new
// key. each block's result appears on block_out and last_out for exactly
// one cycle, marked by done, after the 48 round cells and the output
// register. results leave in start order and the receiver cannot stall
// them. keys, direction and mode must be written through the cfg port only
// while no block is in flight; the unit itself does not enforce this.
module triple_des_block_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] block_in,
	input  logic        last_in,
	output logic        done,
	output logic [63:0] block_out,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [tdes_pkg::IdxW-1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_first_q;
	logic [63:0] key_second_q;
	logic [63:0] key_third_q;
	logic        direction_q;
	logic        triple_q;
	logic        busy_q;

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;

	// hold off a start in the cycle after a register write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= cfg_valid & cfg_ready;
		end
	end

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q  <= '0;
			key_second_q <= '0;
			key_third_q  <= '0;
			direction_q  <= 1'b0;
			triple_q     <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdes_pkg::RegKeyFirst:  key_first_q  <= cfg_data;
				tdes_pkg::RegKeySecond: key_second_q <= cfg_data;
				tdes_pkg::RegKeyThird:  key_third_q  <= cfg_data;
				tdes_pkg::RegDirection: direction_q  <= cfg_data[0];
				tdes_pkg::RegTriple:    triple_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per pass key and direction; single mode runs key_first then two
	// passes that cancel (e then d with key_first) which keeps the chain fixed
	logic [63:0] pass_key [3];
	logic        pass_dec [3];

	always_comb begin
		if (!triple_q) begin
			pass_key[0] = key_first_q;  pass_dec[0] = direction_q;
			pass_key[1] = key_first_q;  pass_dec[1] = 1'b0;
			pass_key[2] = key_first_q;  pass_dec[2] = 1'b1;
		end else if (!direction_q) begin
			pass_key[0] = key_first_q;  pass_dec[0] = 1'b0;
			pass_key[1] = key_second_q; pass_dec[1] = 1'b1;
			pass_key[2] = key_third_q;  pass_dec[2] = 1'b0;
		end else begin
			pass_key[0] = key_third_q;  pass_dec[0] = 1'b1;
			pass_key[1] = key_second_q; pass_dec[1] = 1'b0;
			pass_key[2] = key_first_q;  pass_dec[2] = 1'b1;
		end
	end

	tdes_pkg::subkeys_t  pass_sk [3];
	tdes_pkg::cell_data_t link [tdes_pkg::CellCount+1];
	tdes_pkg::cell_data_t pass_in [3];
	tdes_pkg::cell_data_t pass_out [3];

	// each pass: ip on entry, fp (with the half swap) on exit
	always_comb begin
		logic [63:0] t;
		for (int p = 0; p < 3; p++) begin
			pass_out[p] = link[(p+1)*tdes_pkg::RoundCount];
		end
		t = tdes_pkg::ip_perm(block_in);
		pass_in[0] = '{valid: start & ~busy_q, last: last_in, l: t[63:32], r: t[31:0]};
		for (int p = 1; p < 3; p++) begin
			t = tdes_pkg::ip_perm(tdes_pkg::fp_perm({pass_out[p-1].r, pass_out[p-1].l}));
			pass_in[p] = '{valid: pass_out[p-1].valid, last: pass_out[p-1].last,
				l: t[63:32], r: t[31:0]};
		end
	end

	for (genvar p = 0; p < 3; p++) begin : g_pass
		tdes_key_sched u_ks (
			.clk     (clk),
			.key     (pass_key[p]),
			.decrypt (pass_dec[p]),
			.subkeys (pass_sk[p])
		);
		for (genvar n = 0; n < tdes_pkg::RoundCount; n++) begin : g_cell
			tdes_round_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.d_in   ((n == 0) ? pass_in[p] : link[p*tdes_pkg::RoundCount+n]),
				.subkey (pass_sk[p][n]),
				.d_out  (link[p*tdes_pkg::RoundCount+n+1])
			);
		end
	end

	assign link[0] = pass_in[0];

	// output register
	logic        done_q;
	logic [63:0] block_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pass_out[2].valid;
		end
	end

	always_ff @(posedge clk) begin
		block_q <= tdes_pkg::fp_perm({pass_out[2].r, pass_out[2].l});
		last_q  <= pass_out[2].last;
	end

	assign done      = done_q;
	assign block_out = block_q;
	assign last_out  = last_q;

endmodule

/* hdl/tdes_key_sched.sv */
// tdes_key_sched: registered sixteen round keys for one des key and direction
// depends on tdes_pkg
module tdes_key_sched (
	input  logic               clk,
	input  logic [63:0]        key,
	input  logic               decrypt,
	output tdes_pkg::subkeys_t subkeys
);

	tdes_pkg::subkeys_t sk_q;
	tdes_pkg::subkeys_t sk_next;

	// fixed rotations only, so the chain is wiring plus pc-2 taps
	always_comb begin
		logic [27:0] c;
		logic [27:0] d;
		logic [55:0] cd;
		tdes_pkg::subkey_t k;
		tdes_pkg::subkeys_t fwd;
		for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(tdes_pkg::TabPc1[i])];
		c = cd[55:28];
		d = cd[27:0];
		for (int n = 0; n < tdes_pkg::RoundCount; n++) begin
			c  = tdes_pkg::rotl28(c, tdes_pkg::TabShift[n]);
			d  = tdes_pkg::rotl28(d, tdes_pkg::TabShift[n]);
			cd = {c, d};
			for (int i = 0; i < 48; i++) k[47-i] = cd[56-int'(tdes_pkg::TabPc2[i])];
			fwd[n] = k;
		end
		for (int n = 0; n < tdes_pkg::RoundCount; n++)
			subkeys[n] = sk_q[n];
		for (int n = 0; n < tdes_pkg::RoundCount; n++)
			if (decrypt) sk_next[n] = fwd[tdes_pkg::RoundCount-1-n];
			else sk_next[n] = fwd[n];
	end

	always_ff @(posedge clk) begin
		sk_q <= sk_next;
	end

endmodule

/* hdl/tdes_round_cell.sv */
// tdes_round_cell: one feistel round with its pipeline register
// depends on tdes_pkg
module tdes_round_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdes_pkg::cell_data_t d_in,
	input  tdes_pkg::subkey_t    subkey,
	output tdes_pkg::cell_data_t d_out
);

	tdes_pkg::cell_data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q.valid <= d_in.valid;
			data_q.last  <= d_in.last;
			data_q.l     <= d_in.r;
			data_q.r     <= d_in.l ^ tdes_pkg::feistel(d_in.r, subkey);
		end
	end

	assign d_out = data_q;

endmodule

/* hdl/tdes_checker.sv */
// tdes_checker: port level checks for triple_des_block_cipher_unit
// depends on the top level's ports only
module tdes_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	// block pipeline: every start taken while busy is low gives one done
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##49 done) else $error("missing result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 49)) else $error("result without start");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("config port stalled");

endmodule

bind triple_des_block_cipher_unit tdes_checker u_tdes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);
